// ----- design/macd_pkg.sv -----
`timescale 1ns / 1ps
package macd_pkg;

  localparam int MAX_AGENTS = 16;
  localparam int COORD_BITS = 10;
  localparam int STEP_BITS  = 16;

  localparam int AIDX_BITS = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;

  // fixed port widths
  localparam int POS_W   = 10;
  localparam int AGENT_W = 4;
  localparam int AGENT_O = 4;
  localparam int STEP_W  = 16;

  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_EDGE   = 2'd2
  } kind_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [AIDX_BITS-1:0]  aidx_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } cell_t;

  typedef struct packed {
    kind_t kind;
    aidx_t a;
    aidx_t b;
    cell_t src;
    cell_t dst;
    step_t step;
  } rec_t;

  typedef struct packed {
    logic  found;
    kind_t kind;
    aidx_t a;
    cell_t src;
    cell_t dst;
  } hit_t;

endpackage

// ----- design/macd_match.sv -----
`timescale 1ns / 1ps
module macd_match import macd_pkg::*; (
  input  cell_t                 cur_cells  [MAX_AGENTS],
  input  cell_t                 prev_cells [MAX_AGENTS],
  input  logic [MAX_AGENTS-1:0] cur_seen,
  input  logic [MAX_AGENTS-1:0] prev_seen,
  input  aidx_t                 agent_b,
  input  cell_t                 pos,
  input  logic                  step_nz,
  output hit_t                  hit
);

  logic  b_prev;
  cell_t b_src;

  assign b_prev = prev_seen[agent_b];
  assign b_src  = prev_cells[agent_b];

  // one lane per stored agent; walking down leaves the lowest agent a in hit
  always_comb begin
    hit = '0;
    for (int a = MAX_AGENTS - 1; a >= 0; a--) begin
      if ((aidx_t'(a) < agent_b) && cur_seen[a]) begin
        if (cur_cells[a] == pos) begin
          hit.found = 1'b1;
          hit.kind  = KIND_VERTEX;
          hit.a     = aidx_t'(a);
          hit.src   = pos;
          hit.dst   = '0;
        end else if (step_nz && b_prev && prev_seen[a] &&
                     (prev_cells[a] == pos) && (cur_cells[a] == b_src)) begin
          hit.found = 1'b1;
          hit.kind  = KIND_EDGE;
          hit.a     = aidx_t'(a);
          hit.src   = prev_cells[a];
          hit.dst   = cur_cells[a];
        end
      end
    end
  end

endmodule

// ----- design/multi_agent_conflict_detector_unit.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | pos_x, pos_y, agent_index, last_agent, new_set
// out_     | output    | out_valid/out_stall| conflict_kind, agent_first, agent_second,
//          |           |                    | cell_x, cell_y, dest_x, dest_y, conflict_step
//
// One transaction per cycle sustained while in_stall is low; a result is formed from
// the transaction carrying last_agent via the input register, then one compare
// pass against the per-agent cell registers into the result register.
// rst_n is synchronous: it clears the seen masks, step counter and held conflict.
// in_stall rises only when a last_agent transaction waits on a result still stalled.
module multi_agent_conflict_detector_unit import macd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  input  logic [AGENT_W-1:0] in_agent_index,
  input  logic               in_last_agent,
  input  logic               in_new_set,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_conflict_kind,
  output logic [AGENT_O-1:0] out_agent_first,
  output logic [AGENT_O-1:0] out_agent_second,
  output logic [POS_W-1:0]   out_cell_x,
  output logic [POS_W-1:0]   out_cell_y,
  output logic [POS_W-1:0]   out_dest_x,
  output logic [POS_W-1:0]   out_dest_y,
  output logic [STEP_W-1:0]  out_conflict_step
);

  // input register
  logic               s1_valid_r;
  cell_t              s1_pos_r;
  logic [AGENT_W-1:0] s1_agent_r;
  logic               s1_last_r;
  logic               s1_new_r;

  // agent state
  cell_t                 cur_cells_r   [MAX_AGENTS];
  cell_t                 cur_cells_nxt [MAX_AGENTS];
  cell_t                 prev_cells_r  [MAX_AGENTS];
  cell_t                 prev_cells_nxt[MAX_AGENTS];
  logic [MAX_AGENTS-1:0] cur_seen_r, cur_seen_nxt;
  logic [MAX_AGENTS-1:0] prev_seen_r, prev_seen_nxt;
  step_t                 step_r, step_nxt;
  logic                  best_valid_r, best_valid_nxt;
  rec_t                  best_r, best_nxt;
  rec_t                  held_r, held_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;

  logic                  fire;
  logic                  in_take;
  logic                  in_range;
  aidx_t                 agent_b;
  logic [MAX_AGENTS-1:0] cur_seen_e, prev_seen_e, seen_upd;
  step_t                 step_e;
  logic                  best_valid_e, best_valid_upd;
  rec_t                  best_e, best_upd, held_e, held_upd, cand;
  logic                  better;
  hit_t                  hit;

  assign fire     = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pos_r   <= '{x: COORD_BITS'(in_pos_x), y: COORD_BITS'(in_pos_y)};
      s1_agent_r <= in_agent_index;
      s1_last_r  <= in_last_agent;
      s1_new_r   <= in_new_set;
    end
  end

  // new_set starts from a cleared view of the state
  assign cur_seen_e   = s1_new_r ? '0 : cur_seen_r;
  assign prev_seen_e  = s1_new_r ? '0 : prev_seen_r;
  assign step_e       = s1_new_r ? '0 : step_r;
  assign best_valid_e = s1_new_r ? 1'b0 : best_valid_r;
  assign best_e       = s1_new_r ? '0 : best_r;
  assign held_e       = s1_new_r ? '0 : held_r;

  assign in_range = int'(s1_agent_r) < MAX_AGENTS;
  assign agent_b  = aidx_t'(s1_agent_r);

  macd_match u_match (
    .cur_cells  (cur_cells_r),
    .prev_cells (prev_cells_r),
    .cur_seen   (cur_seen_e),
    .prev_seen  (prev_seen_e),
    .agent_b    (agent_b),
    .pos        (s1_pos_r),
    .step_nz    (step_e != '0),
    .hit        (hit)
  );

  assign cand = '{kind: hit.kind, a: hit.a, b: agent_b, src: hit.src, dst: hit.dst,
                  step: step_e};

  assign better = hit.found && in_range &&
                  (!best_valid_e || (hit.a < best_e.a) ||
                   ((hit.a == best_e.a) && (agent_b < best_e.b)));

  assign best_upd       = better ? cand : best_e;
  assign best_valid_upd = best_valid_e || better;
  assign held_upd       = ((held_e.kind == KIND_NONE) && best_valid_upd) ? best_upd : held_e;
  assign seen_upd       = cur_seen_e | (in_range ? (MAX_AGENTS'(1) << agent_b) : '0);

  always_comb begin
    cur_seen_nxt   = cur_seen_r;
    prev_seen_nxt  = prev_seen_r;
    step_nxt       = step_r;
    best_valid_nxt = best_valid_r;
    best_nxt       = best_r;
    held_nxt       = held_r;
    out_rec_nxt    = out_rec_r;
    out_valid_nxt  = out_valid_r && out_stall;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      cur_cells_nxt[i]  = cur_cells_r[i];
      prev_cells_nxt[i] = prev_cells_r[i];
    end
    if (fire) begin
      if (in_range) begin
        cur_cells_nxt[agent_b] = s1_pos_r;
      end
      if (s1_last_r) begin
        // close the timestep
        for (int i = 0; i < MAX_AGENTS; i++) begin
          prev_cells_nxt[i] = cur_cells_nxt[i];
        end
        prev_seen_nxt  = seen_upd;
        cur_seen_nxt   = '0;
        best_valid_nxt = 1'b0;
        best_nxt       = '0;
        held_nxt       = held_upd;
        step_nxt       = (step_e != STEP_MAX) ? STEP_BITS'(step_e + 1'b1) : step_e;
        out_rec_nxt    = held_upd;
        out_valid_nxt  = 1'b1;
      end else begin
        prev_seen_nxt  = prev_seen_e;
        cur_seen_nxt   = seen_upd;
        best_valid_nxt = best_valid_upd;
        best_nxt       = best_upd;
        held_nxt       = held_e;
        step_nxt       = step_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_seen_r   <= '0;
      prev_seen_r  <= '0;
      step_r       <= '0;
      best_valid_r <= 1'b0;
      best_r       <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_seen_r   <= cur_seen_nxt;
      prev_seen_r  <= prev_seen_nxt;
      step_r       <= step_nxt;
      best_valid_r <= best_valid_nxt;
      best_r       <= best_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_AGENTS; i++) begin
      cur_cells_r[i]  <= cur_cells_nxt[i];
      prev_cells_r[i] <= prev_cells_nxt[i];
    end
    out_rec_r <= out_rec_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_conflict_kind = out_rec_r.kind;
  assign out_agent_first   = AGENT_O'(out_rec_r.a);
  assign out_agent_second  = AGENT_O'(out_rec_r.b);
  assign out_cell_x        = POS_W'(out_rec_r.src.x);
  assign out_cell_y        = POS_W'(out_rec_r.src.y);
  assign out_dest_x        = POS_W'(out_rec_r.dst.x);
  assign out_dest_y        = POS_W'(out_rec_r.dst.y);
  assign out_conflict_step = STEP_W'(out_rec_r.step);

endmodule

// ----- design/macd_checker.sv -----
`timescale 1ns / 1ps
module macd_checker import macd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_conflict_kind,
  input logic [AGENT_O-1:0] out_agent_first,
  input logic [AGENT_O-1:0] out_agent_second,
  input logic [POS_W-1:0]   out_cell_x,
  input logic [POS_W-1:0]   out_cell_y,
  input logic [POS_W-1:0]   out_dest_x,
  input logic [POS_W-1:0]   out_dest_y,
  input logic [STEP_W-1:0]  out_conflict_step
);

  // no result survives reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_conflict_kind) &&
      $stable(out_agent_first) && $stable(out_agent_second) &&
      $stable(out_cell_x) && $stable(out_cell_y) && $stable(out_dest_x) &&
      $stable(out_dest_y) && $stable(out_conflict_step))
    else $error("stalled result changed");

  // no conflict yet means an all-zero record
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_conflict_kind == KIND_NONE) |->
      (out_agent_first == '0) && (out_agent_second == '0) && (out_cell_x == '0) &&
      (out_cell_y == '0) && (out_dest_x == '0) && (out_dest_y == '0) &&
      (out_conflict_step == '0))
    else $error("non-zero fields without a conflict");

  // a conflict pairs a lower agent with a higher one
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_conflict_kind != KIND_NONE) |->
      (out_agent_first < out_agent_second) &&
      ((out_conflict_kind == KIND_VERTEX) || (out_conflict_kind == KIND_EDGE)))
    else $error("bad conflict pair or kind");

  // a vertex conflict carries no destination
  a_vertex_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_conflict_kind == KIND_VERTEX) |->
      (out_dest_x == '0) && (out_dest_y == '0))
    else $error("vertex conflict with a destination");

endmodule

bind multi_agent_conflict_detector_unit macd_checker u_macd_checker (.*);

// ----- tb/macd_conflict_checker.sv -----
`timescale 1ns / 1ps
module macd_conflict_checker import macd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  input  logic [AGENT_W-1:0] in_agent_index,
  input  logic               in_last_agent,
  input  logic               in_new_set,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_conflict_kind,
  input  logic [AGENT_O-1:0] out_agent_first,
  input  logic [AGENT_O-1:0] out_agent_second,
  input  logic [POS_W-1:0]   out_cell_x,
  input  logic [POS_W-1:0]   out_cell_y,
  input  logic [POS_W-1:0]   out_dest_x,
  input  logic [POS_W-1:0]   out_dest_y,
  input  logic [STEP_W-1:0]  out_conflict_step,
  output int                 mismatches,
  output int                 pending,
  output int                 reports_seen,
  output int                 vertex_seen,
  output int                 edge_seen
);

  cell_t                 now_cell [MAX_AGENTS];
  cell_t                 was_cell [MAX_AGENTS];
  logic [MAX_AGENTS-1:0] now_seen;
  logic [MAX_AGENTS-1:0] was_seen;
  step_t                 step_no;
  logic                  step_hit;
  rec_t                  step_best;
  rec_t                  held_conflict;
  rec_t                  expected_reports [$];

  function automatic void clear_paths();
    for (int i = 0; i < MAX_AGENTS; i++) begin
      now_cell[i] = '0;
      was_cell[i] = '0;
    end
    now_seen      = '0;
    was_seen      = '0;
    step_no       = '0;
    step_hit      = 1'b0;
    step_best     = '0;
    held_conflict = '0;
  endfunction

  // Compares one arriving cell against lower-numbered agents of this timestep;
  // the first hitting agent a ends the scan for this agent b.
  function automatic void track_position(cell_t pos, logic [AGENT_W-1:0] agent,
                                         logic closes, logic fresh);
    rec_t cand;
    logic got;
    if (fresh)
      clear_paths();
    got = 1'b0;
    for (int a = 0; a < int'(agent) && !got; a++) begin
      if (now_seen[a]) begin
        cand      = '0;
        cand.a    = aidx_t'(a);
        cand.b    = aidx_t'(agent);
        cand.step = step_no;
        if (now_cell[a] == pos) begin
          cand.kind = KIND_VERTEX;
          cand.src  = pos;
          got       = 1'b1;
        end else if (step_no != '0 && was_seen[agent] && was_seen[a] &&
                     was_cell[a] == pos && now_cell[a] == was_cell[agent]) begin
          cand.kind = KIND_EDGE;
          cand.src  = was_cell[a];
          cand.dst  = now_cell[a];
          got       = 1'b1;
        end
        if (got && (!step_hit || cand.a < step_best.a ||
                    (cand.a == step_best.a && cand.b < step_best.b))) begin
          step_best = cand;
          step_hit  = 1'b1;
        end
      end
    end
    now_cell[agent] = pos;
    now_seen[agent] = 1'b1;
    if (closes) begin
      if (held_conflict.kind == KIND_NONE && step_hit)
        held_conflict = step_best;
      expected_reports.insert(expected_reports.size(), held_conflict);
      for (int i = 0; i < MAX_AGENTS; i++)
        was_cell[i] = now_cell[i];
      was_seen  = now_seen;
      now_seen  = '0;
      step_hit  = 1'b0;
      step_best = '0;
      if (step_no != STEP_MAX)
        step_no = step_no + 1'b1;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rec_t want;
    cell_t pos;
    if (!rst_n) begin
      clear_paths();
      expected_reports.delete();
      mismatches   = 0;
      reports_seen = 0;
      vertex_seen  = 0;
      edge_seen    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("report with no transaction waiting on it: kind %0d step %0d",
                 out_conflict_kind, out_conflict_step);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("conflict_kind", 32'(want.kind), 32'(out_conflict_kind));
          check_field("agent_first", 32'(want.a), 32'(out_agent_first));
          check_field("agent_second", 32'(want.b), 32'(out_agent_second));
          check_field("cell_x", 32'(want.src.x), 32'(out_cell_x));
          check_field("cell_y", 32'(want.src.y), 32'(out_cell_y));
          check_field("dest_x", 32'(want.dst.x), 32'(out_dest_x));
          check_field("dest_y", 32'(want.dst.y), 32'(out_dest_y));
          check_field("conflict_step", 32'(want.step), 32'(out_conflict_step));
          reports_seen++;
          if (kind_t'(out_conflict_kind) == KIND_VERTEX)
            vertex_seen++;
          if (kind_t'(out_conflict_kind) == KIND_EDGE)
            edge_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        pos.x = in_pos_x;
        pos.y = in_pos_y;
        track_position(pos, in_agent_index, in_last_agent, in_new_set);
      end
    end
    pending <= expected_reports.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import macd_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [POS_W-1:0]   in_pos_x       = '0;
  logic [POS_W-1:0]   in_pos_y       = '0;
  logic [AGENT_W-1:0] in_agent_index = '0;
  logic               in_last_agent  = 1'b0;
  logic               in_new_set     = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         out_conflict_kind;
  logic [AGENT_O-1:0] out_agent_first;
  logic [AGENT_O-1:0] out_agent_second;
  logic [POS_W-1:0]   out_cell_x;
  logic [POS_W-1:0]   out_cell_y;
  logic [POS_W-1:0]   out_dest_x;
  logic [POS_W-1:0]   out_dest_y;
  logic [STEP_W-1:0]  out_conflict_step;

  int mismatches, pending, reports_seen, vertex_seen, edge_seen;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int cycles     = 0;

  multi_agent_conflict_detector_unit uut (.*);

  macd_conflict_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [AGENT_W-1:0] agent, input logic last,
                           input logic fresh);
    // each cycle before the transaction is idle with probability idle_pct
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_agent_index <= agent;
    in_last_agent  <= last;
    in_new_set     <= fresh;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender off until every report owed has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int mode, w, n, steps, d, i1, i2, j, t;
    int px [16];
    int py [16];
    int order [25];
    logic [POS_W-1:0] bx, by;
    int phase_idle  [5] = '{0, 76, 0, 29, 0};
    int phase_stall [5] = '{0, 0, 76, 29, 0};
    int target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner coordinates, then the two agents swap: edge conflict at step 1
    send_item(10'd0, 10'd0, 4'd0, 1'b0, 1'b1);
    send_item(10'd1023, 10'd1023, 4'd1, 1'b1, 1'b0);
    send_item(10'd1023, 10'd1023, 4'd0, 1'b0, 1'b0);
    send_item(10'd0, 10'd0, 4'd1, 1'b1, 1'b0);
    // out-of-order agents hide a shared cell; next step vertex beats the swap
    send_item(10'd0, 10'd1023, 4'd1, 1'b0, 1'b1);
    send_item(10'd0, 10'd1023, 4'd0, 1'b1, 1'b0);
    send_item(10'd0, 10'd1023, 4'd0, 1'b0, 1'b0);
    send_item(10'd0, 10'd1023, 4'd1, 1'b1, 1'b0);
    // two vertex hits in one step: lower agent a wins; held on later steps
    send_item(10'd10, 10'd10, 4'd0, 1'b0, 1'b1);
    send_item(10'd20, 10'd20, 4'd1, 1'b0, 1'b0);
    send_item(10'd20, 10'd20, 4'd2, 1'b0, 1'b0);
    send_item(10'd10, 10'd10, 4'd3, 1'b1, 1'b0);
    send_item(10'd1023, 10'd0, 4'd2, 1'b0, 1'b0);
    send_item(10'd5, 10'd5, 4'd2, 1'b0, 1'b0);
    send_item(10'd7, 10'd9, 4'd3, 1'b1, 1'b0);
    // top agent numbers
    send_item(10'd1023, 10'd1023, 4'd14, 1'b0, 1'b1);
    send_item(10'd1023, 10'd1023, 4'd15, 1'b1, 1'b0);
    // agent 1 absent last step: no swap check for it, edge (0,2) wins
    send_item(10'd1, 10'd2, 4'd0, 1'b0, 1'b1);
    send_item(10'd3, 10'd4, 4'd2, 1'b1, 1'b0);
    send_item(10'd3, 10'd4, 4'd0, 1'b0, 1'b0);
    send_item(10'd1, 10'd2, 4'd1, 1'b0, 1'b0);
    send_item(10'd1, 10'd2, 4'd2, 1'b1, 1'b0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      target    = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < target) begin
        mode = $urandom_range(0, 99);
        if (mode < 80) begin
          // path set: distinct start cells in a small box, then moves and swaps
          w     = $urandom_range(2, 5);
          n     = $urandom_range(2, (w * w < 16) ? w * w : 16);
          steps = $urandom_range(1, 6);
          bx    = POS_W'($urandom_range(0, 1023));
          by    = POS_W'($urandom_range(0, 1023));
          for (int i = 0; i < w * w; i++)
            order[i] = i;
          for (int i = w * w - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
          end
          for (int i = 0; i < n; i++) begin
            px[i] = order[i] % w;
            py[i] = order[i] / w;
          end
          for (int s = 0; s < steps; s++) begin
            if (s > 0) begin
              if ($urandom_range(0, 99) < 35) begin
                i1     = $urandom_range(0, n - 1);
                i2     = (i1 + $urandom_range(1, n - 1)) % n;
                t      = px[i1];
                px[i1] = px[i2];
                px[i2] = t;
                t      = py[i1];
                py[i1] = py[i2];
                py[i2] = t;
              end else begin
                for (int k = 0; k < n; k++) begin
                  d     = int'($urandom_range(0, 2)) - 1;
                  px[k] = px[k] + d;
                  px[k] = (px[k] < 0) ? 0 : (px[k] >= w) ? w - 1 : px[k];
                  d     = int'($urandom_range(0, 2)) - 1;
                  py[k] = py[k] + d;
                  py[k] = (py[k] < 0) ? 0 : (py[k] >= w) ? w - 1 : py[k];
                end
              end
            end
            for (int k = 0; k < n; k++) begin
              if (k != n - 1 && !(s == 0 && k == 0) && $urandom_range(0, 99) < 4)
                continue;
              send_item(POS_W'(bx + px[k]), POS_W'(by + py[k]), AGENT_W'(k),
                        k == n - 1, s == 0 && k == 0);
              if (k < n - 1 && $urandom_range(0, 99) < 3)
                send_item(POS_W'(bx + $urandom_range(0, w - 1)),
                          POS_W'(by + $urandom_range(0, w - 1)), AGENT_W'(k), 1'b0, 1'b0);
            end
          end
        end else begin
          repeat ($urandom_range(1, 8))
            send_item(POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)),
                      AGENT_W'($urandom_range(0, 15)), $urandom_range(0, 9) < 3,
                      $urandom_range(0, 9) == 0);
        end
      end
      drain();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("%0d transactions sent over directed swaps and five idle/stall mixes;",
             items_sent);
    $display("%0d reports checked: %0d vertex, %0d edge", reports_seen, vertex_seen,
             edge_seen);
    if (mismatches == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
